FILE: src/wrp_pkg.sv
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants for the WAV RIFF header parser.
// ----------------------------------------------------------------------------
package wrp_pkg;

  // four-character chunk and form tags, first character in the top byte
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_RIFX = 32'h5249_4658;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // parse ends at a chunk boundary with this many body bytes left or fewer
  localparam logic [31:0] MIN_LEFT = 32'd8;

  // byte kind codes
  localparam logic [1:0] KIND_HDR    = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERR    = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_MAGIC   = 2'd1;
  localparam logic [1:0] ERR_FORM    = 2'd2;
  localparam logic [1:0] ERR_HEADER  = 2'd3;

  // one result item
  typedef struct packed {
    logic [1:0]  byte_kind;
    logic [1:0]  error_code;
    logic [7:0]  sample_byte;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] bytes_per_sec;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
    logic        big_endian;
    logic        header_valid;
  } wrp_res_t;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } wrp_item_t;

endpackage

FILE: src/wrp_in_reg.sv
// ----------------------------------------------------------------------------
// wrp_in_reg
// Input register: holds one byte until the parser can take it.
// ----------------------------------------------------------------------------
module wrp_in_reg
  import wrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  wrp_item_t in_item,
  input  logic      take,
  output logic      held_valid,
  output wrp_item_t held_item
);

  logic      vld_r;
  wrp_item_t item_r;

  // stall only while a held item is not consumed this cycle
  assign in_stall   = vld_r && !take;
  assign held_valid = vld_r;
  assign held_item  = item_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: src/wrp_parse.sv
// ----------------------------------------------------------------------------
// wrp_parse
// Parser state and per-byte step logic: magic, RIFF size, form, chunk walk.
// ----------------------------------------------------------------------------
module wrp_parse
  import wrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  wrp_item_t item,
  output wrp_res_t  res
);

  // parse phases
  localparam logic [2:0] PH_MAGIC = 3'd0;
  localparam logic [2:0] PH_RSIZE = 3'd1;
  localparam logic [2:0] PH_FORM  = 3'd2;
  localparam logic [2:0] PH_CID   = 3'd3;
  localparam logic [2:0] PH_CSIZE = 3'd4;
  localparam logic [2:0] PH_BODY  = 3'd5;
  localparam logic [2:0] PH_OK    = 3'd6;
  localparam logic [2:0] PH_ERR   = 3'd7;

  logic [2:0]  phase_r,  phase_nxt;
  logic [2:0]  fbc_r,    fbc_nxt;
  logic [31:0] acc_r,    acc_nxt;
  logic [31:0] tag_r,    tag_nxt;
  logic [32:0] cbl_r,    cbl_nxt;
  logic [31:0] rbl_r,    rbl_nxt;
  logic [4:0]  foff_r,   foff_nxt;
  logic [15:0] afmt_r,   afmt_nxt;
  logic [15:0] chan_r,   chan_nxt;
  logic [31:0] srate_r,  srate_nxt;
  logic [31:0] brate_r,  brate_nxt;
  logic [15:0] bps_r,    bps_nxt;
  logic [31:0] dlen_r,   dlen_nxt;
  logic        endian_r, endian_nxt;
  logic        dseen_r,  dseen_nxt;
  logic [1:0]  err_r,    err_nxt;

  logic [1:0]  kind;
  logic [7:0]  sample;
  logic        at_bound;
  logic [7:0]  b;

  assign b = item.data_byte;

  // one byte step
  always_comb begin
    logic [31:0] num_acc;
    logic [4:0]  off;
    logic [31:0] sz;

    // start of a new file clears everything before the byte is used
    if (item.file_start) begin
      phase_nxt  = PH_MAGIC;
      fbc_nxt    = '0;
      acc_nxt    = '0;
      tag_nxt    = '0;
      cbl_nxt    = '0;
      rbl_nxt    = '0;
      foff_nxt   = '0;
      afmt_nxt   = '0;
      chan_nxt   = '0;
      srate_nxt  = '0;
      brate_nxt  = '0;
      bps_nxt    = '0;
      dlen_nxt   = '0;
      endian_nxt = 1'b0;
      dseen_nxt  = 1'b0;
      err_nxt    = ERR_NONE;
    end else begin
      phase_nxt  = phase_r;
      fbc_nxt    = fbc_r;
      acc_nxt    = acc_r;
      tag_nxt    = tag_r;
      cbl_nxt    = cbl_r;
      rbl_nxt    = rbl_r;
      foff_nxt   = foff_r;
      afmt_nxt   = afmt_r;
      chan_nxt   = chan_r;
      srate_nxt  = srate_r;
      brate_nxt  = brate_r;
      bps_nxt    = bps_r;
      dlen_nxt   = dlen_r;
      endian_nxt = endian_r;
      dseen_nxt  = dseen_r;
      err_nxt    = err_r;
    end

    kind     = KIND_HDR;
    sample   = '0;
    at_bound = 1'b0;
    off      = foff_nxt;
    sz       = '0;

    // number accumulation in file byte order
    if (endian_nxt) begin
      num_acc = {acc_nxt[23:0], b};
    end else begin
      num_acc = acc_nxt | ({24'd0, b} << {fbc_nxt[1:0], 3'b000});
    end

    unique case (phase_nxt)
      PH_MAGIC: begin
        tag_nxt = {tag_nxt[23:0], b};
        fbc_nxt = fbc_nxt + 3'd1;
        if (fbc_nxt >= 3'd4) begin
          if (tag_nxt == TAG_RIFF || tag_nxt == TAG_RIFX) begin
            endian_nxt = (tag_nxt == TAG_RIFX);
            phase_nxt  = PH_RSIZE;
            acc_nxt    = '0;
            fbc_nxt    = '0;
          end else begin
            err_nxt   = ERR_MAGIC;
            phase_nxt = PH_ERR;
            kind      = KIND_ERR;
          end
        end
      end
      PH_RSIZE: begin
        acc_nxt = num_acc;
        fbc_nxt = fbc_nxt + 3'd1;
        if (fbc_nxt >= 3'd4) begin
          rbl_nxt   = (acc_nxt >= 32'd4) ? acc_nxt - 32'd4 : 32'd0;
          tag_nxt   = '0;
          acc_nxt   = '0;
          fbc_nxt   = '0;
          phase_nxt = PH_FORM;
        end
      end
      PH_FORM: begin
        tag_nxt = {tag_nxt[23:0], b};
        fbc_nxt = fbc_nxt + 3'd1;
        if (fbc_nxt >= 3'd4) begin
          if (tag_nxt == TAG_WAVE) begin
            at_bound = 1'b1;
          end else begin
            err_nxt   = ERR_FORM;
            phase_nxt = PH_ERR;
            kind      = KIND_ERR;
          end
        end
      end
      PH_CID: begin
        if (rbl_nxt != '0) rbl_nxt = rbl_nxt - 32'd1;
        tag_nxt = {tag_nxt[23:0], b};
        fbc_nxt = fbc_nxt + 3'd1;
        if (fbc_nxt >= 3'd4) begin
          acc_nxt   = '0;
          fbc_nxt   = '0;
          phase_nxt = PH_CSIZE;
        end
      end
      PH_CSIZE: begin
        if (rbl_nxt != '0) rbl_nxt = rbl_nxt - 32'd1;
        acc_nxt = num_acc;
        fbc_nxt = fbc_nxt + 3'd1;
        if (fbc_nxt >= 3'd4) begin
          sz      = acc_nxt;
          // body length rounded up to even for the pad byte
          cbl_nxt = {1'b0, sz} + {32'd0, sz[0]};
          if (tag_nxt == TAG_DATA) begin
            dlen_nxt  = sz;
            dseen_nxt = 1'b1;
          end
          foff_nxt = '0;
          acc_nxt  = '0;
          fbc_nxt  = '0;
          if (cbl_nxt == '0) begin
            at_bound = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (rbl_nxt != '0) rbl_nxt = rbl_nxt - 32'd1;
        if (tag_nxt == TAG_DATA) begin
          // pad byte of an odd-sized data chunk is not a sample
          if (cbl_nxt > {32'd0, dlen_nxt[0]}) begin
            kind   = KIND_SAMPLE;
            sample = b;
          end
        end else if (tag_nxt == TAG_FMT) begin
          if (off < 5'd16) begin
            acc_nxt  = num_acc;
            fbc_nxt  = fbc_nxt + 3'd1;
            foff_nxt = off + 5'd1;
            // field ends: latch and restart the accumulator
            unique case (off)
              5'd1:  afmt_nxt  = acc_nxt[15:0];
              5'd3:  chan_nxt  = acc_nxt[15:0];
              5'd7:  srate_nxt = acc_nxt;
              5'd11: brate_nxt = acc_nxt;
              5'd15: bps_nxt   = acc_nxt[15:0];
              default: ;
            endcase
            if (off == 5'd1 || off == 5'd3 || off == 5'd7 || off == 5'd11 ||
                off == 5'd13 || off == 5'd15) begin
              acc_nxt = '0;
              fbc_nxt = '0;
            end
          end
        end
        cbl_nxt = cbl_nxt - 33'd1;
        if (cbl_nxt == '0) at_bound = 1'b1;
      end
      PH_ERR: begin
        kind = KIND_ERR;
      end
      default: begin
        phase_nxt = PH_OK;
      end
    endcase

    // chunk boundary: next chunk or end of parse
    if (at_bound) begin
      if (rbl_nxt > MIN_LEFT) begin
        phase_nxt = PH_CID;
        tag_nxt   = '0;
        acc_nxt   = '0;
        fbc_nxt   = '0;
      end else if (dlen_nxt == '0 || srate_nxt == '0) begin
        err_nxt   = ERR_HEADER;
        phase_nxt = PH_ERR;
        kind      = KIND_ERR;
      end else begin
        phase_nxt = PH_OK;
        kind      = KIND_DONE;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC;
      fbc_r    <= '0;
      acc_r    <= '0;
      tag_r    <= '0;
      cbl_r    <= '0;
      rbl_r    <= '0;
      foff_r   <= '0;
      afmt_r   <= '0;
      chan_r   <= '0;
      srate_r  <= '0;
      brate_r  <= '0;
      bps_r    <= '0;
      dlen_r   <= '0;
      endian_r <= 1'b0;
      dseen_r  <= 1'b0;
      err_r    <= ERR_NONE;
    end else if (go) begin
      phase_r  <= phase_nxt;
      fbc_r    <= fbc_nxt;
      acc_r    <= acc_nxt;
      tag_r    <= tag_nxt;
      cbl_r    <= cbl_nxt;
      rbl_r    <= rbl_nxt;
      foff_r   <= foff_nxt;
      afmt_r   <= afmt_nxt;
      chan_r   <= chan_nxt;
      srate_r  <= srate_nxt;
      brate_r  <= brate_nxt;
      bps_r    <= bps_nxt;
      dlen_r   <= dlen_nxt;
      endian_r <= endian_nxt;
      dseen_r  <= dseen_nxt;
      err_r    <= err_nxt;
    end
  end

  // result of this byte
  always_comb begin
    res.byte_kind       = kind;
    res.error_code      = err_nxt;
    res.sample_byte     = sample;
    res.audio_format    = afmt_nxt;
    res.channel_count   = chan_nxt;
    res.sample_rate     = srate_nxt;
    res.bytes_per_sec   = brate_nxt;
    res.bits_per_sample = bps_nxt;
    res.data_size       = dlen_nxt;
    res.big_endian      = endian_nxt;
    res.header_valid    = dseen_nxt;
  end

endmodule

FILE: src/wrp_out_reg.sv
// ----------------------------------------------------------------------------
// wrp_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module wrp_out_reg
  import wrp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     held_valid,
  input  wrp_res_t res,
  output logic     take,
  output logic     out_valid,
  input  logic     out_stall,
  output wrp_res_t out_res
);

  logic     vld_r;
  wrp_res_t res_r;

  // load when empty or when the current item leaves this cycle
  assign take      = held_valid && (!vld_r || !out_stall);
  assign out_valid = vld_r;
  assign out_res   = res_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

endmodule

FILE: src/wav_riff_header_parser_unit.sv
// ----------------------------------------------------------------------------
// wav_riff_header_parser_unit
// Byte-stream WAV header parser: checks RIFF/RIFX and WAVE, walks chunks,
// extracts fmt fields and marks data chunk bytes as samples.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_stall, in_data_byte,      | in
//          | in_file_start                          |
//  result  | out_valid, out_stall, out_byte_kind .. | out
//          | out_header_valid                       |
//
//  One result item per input item. An item waits in the input register and
//  is stepped through the parser into the result register; one item is
//  taken every cycle while the result side does not stall.
//  The rate is set by the single step of the parser state registers.
//  Reset (rst_n low, synchronous) empties both registers and returns the
//  parser to the magic phase. A stall on the result side holds the result
//  register and then the input register.
// ----------------------------------------------------------------------------
module wav_riff_header_parser_unit
  import wrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_file_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_byte_kind,
  output logic [1:0]  out_error_code,
  output logic [7:0]  out_sample_byte,
  output logic [15:0] out_audio_format,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [31:0] out_bytes_per_sec,
  output logic [15:0] out_bits_per_sample,
  output logic [31:0] out_data_size,
  output logic        out_big_endian,
  output logic        out_header_valid
);

  wrp_item_t in_item;
  wrp_item_t held_item;
  logic      held_valid;
  logic      take;
  wrp_res_t  res;
  wrp_res_t  out_res;

  assign in_item.data_byte  = in_data_byte;
  assign in_item.file_start = in_file_start;

  // input register
  wrp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // parser
  wrp_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (take),
    .item  (held_item),
    .res   (res)
  );

  // result register
  wrp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .held_valid (held_valid),
    .res        (res),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  // result fields
  assign out_byte_kind       = out_res.byte_kind;
  assign out_error_code      = out_res.error_code;
  assign out_sample_byte     = out_res.sample_byte;
  assign out_audio_format    = out_res.audio_format;
  assign out_channel_count   = out_res.channel_count;
  assign out_sample_rate     = out_res.sample_rate;
  assign out_bytes_per_sec   = out_res.bytes_per_sec;
  assign out_bits_per_sample = out_res.bits_per_sample;
  assign out_data_size       = out_res.data_size;
  assign out_big_endian      = out_res.big_endian;
  assign out_header_valid    = out_res.header_valid;

endmodule

FILE: tb/sv/wav_riff_header_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// wav_riff_header_parser_unit_tb
// Self-checking bench for the WAV RIFF header parser. A few hand-made
// broken headers come first, then randomly built RIFF/RIFX files (fmt, data
// and skipped chunks, odd sizes, short and huge sizes, trailing bytes), cut
// files and noise bytes. Every accepted byte is stepped through a parser
// model in the scoreboard and each result item is checked field by field.
// ----------------------------------------------------------------------------
module wav_riff_header_parser_unit_tb;
  import wrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
  localparam int unsigned LIVE_BYTES = 1250;

  typedef enum logic [3:0] {
    P_MAGIC, P_RIFF_SIZE, P_FORM, P_CHUNK_ID, P_CHUNK_SIZE, P_BODY, P_DONE, P_ERROR
  } parse_phase_t;

  // parser model and store of expected result items
  class wav_parse_checker;
    parse_phase_t phase;
    logic [2:0]   fcnt;
    logic [31:0]  acc;
    logic [31:0]  tag;
    logic [32:0]  chunk_left;
    logic [31:0]  riff_left;
    logic [4:0]   fmt_off;
    logic [15:0]  fmt_format, fmt_channels, fmt_bits;
    logic [31:0]  fmt_rate, fmt_bytes_sec;
    logic [31:0]  data_len;
    logic         big;
    logic         data_seen;
    logic [1:0]   err;

    wrp_res_t expected_parse_q[$];
    int unsigned fail_count, checked_count;
    int unsigned sample_count, done_count, error_count;

    function new();
      clear_all();
    endfunction

    function void clear_all();
      phase = P_MAGIC;
      fcnt = '0;
      acc = '0;
      tag = '0;
      chunk_left = '0;
      riff_left = '0;
      fmt_off = '0;
      fmt_format = '0;
      fmt_channels = '0;
      fmt_bits = '0;
      fmt_rate = '0;
      fmt_bytes_sec = '0;
      data_len = '0;
      big = 1'b0;
      data_seen = 1'b0;
      err = ERR_NONE;
    endfunction

    function void clear_field();
      acc = '0;
      fcnt = '0;
    endfunction

    // number bytes follow the file's byte order
    function void take_num(logic [7:0] b);
      if (big) acc = {acc[23:0], b};
      else acc = acc | (32'(b) << (8 * fcnt[1:0]));
      fcnt = fcnt + 3'd1;
    endfunction

    function void take_tag(logic [7:0] b);
      tag = {tag[23:0], b};
      fcnt = fcnt + 3'd1;
    endfunction

    // chunk boundary: next chunk, or end of the parse
    function logic [1:0] boundary(logic [1:0] kind);
      if (riff_left > MIN_LEFT) begin
        phase = P_CHUNK_ID;
        tag = '0;
        clear_field();
        return kind;
      end
      if (data_len == 32'd0 || fmt_rate == 32'd0) begin
        err = ERR_HEADER;
        phase = P_ERROR;
        return KIND_ERR;
      end
      phase = P_DONE;
      return KIND_DONE;
    endfunction

    // only the first 16 fmt body bytes carry fields
    function void fmt_byte(logic [7:0] b);
      logic [4:0] off;
      off = fmt_off;
      if (off < 5'd16) begin
        take_num(b);
        fmt_off = off + 5'd1;
        case (off)
          5'd1: begin
            fmt_format = acc[15:0];
            clear_field();
          end
          5'd3: begin
            fmt_channels = acc[15:0];
            clear_field();
          end
          5'd7: begin
            fmt_rate = acc;
            clear_field();
          end
          5'd11: begin
            fmt_bytes_sec = acc;
            clear_field();
          end
          5'd13: clear_field();
          5'd15: begin
            fmt_bits = acc[15:0];
            clear_field();
          end
          default: ;
        endcase
      end
    endfunction

    // step the model on an accepted item; returns 0 if the parse had already ended
    function bit note_byte(logic [7:0] b, logic start);
      wrp_res_t   r;
      logic [1:0] kind;
      logic [7:0] smp;
      logic [31:0] sz;
      bit         live;
      if (start) clear_all();
      live = (phase != P_DONE) && (phase != P_ERROR);
      kind = KIND_HDR;
      smp = '0;
      case (phase)
        P_MAGIC: begin
          take_tag(b);
          if (fcnt >= 3'd4) begin
            if (tag == TAG_RIFF || tag == TAG_RIFX) begin
              big = (tag == TAG_RIFX);
              phase = P_RIFF_SIZE;
              clear_field();
            end else begin
              err = ERR_MAGIC;
              phase = P_ERROR;
              kind = KIND_ERR;
            end
          end
        end
        P_RIFF_SIZE: begin
          take_num(b);
          if (fcnt >= 3'd4) begin
            riff_left = (acc >= 32'd4) ? acc - 32'd4 : 32'd0;
            tag = '0;
            clear_field();
            phase = P_FORM;
          end
        end
        P_FORM: begin
          take_tag(b);
          if (fcnt >= 3'd4) begin
            if (tag == TAG_WAVE) begin
              kind = boundary(KIND_HDR);
            end else begin
              err = ERR_FORM;
              phase = P_ERROR;
              kind = KIND_ERR;
            end
          end
        end
        P_CHUNK_ID: begin
          if (riff_left != 0) riff_left = riff_left - 32'd1;
          take_tag(b);
          if (fcnt >= 3'd4) begin
            clear_field();
            phase = P_CHUNK_SIZE;
          end
        end
        P_CHUNK_SIZE: begin
          if (riff_left != 0) riff_left = riff_left - 32'd1;
          take_num(b);
          if (fcnt >= 3'd4) begin
            sz = acc;
            chunk_left = {1'b0, sz} + {32'd0, sz[0]};
            if (tag == TAG_DATA) begin
              data_len = sz;
              data_seen = 1'b1;
            end
            fmt_off = '0;
            clear_field();
            if (chunk_left == 33'd0) kind = boundary(KIND_HDR);
            else phase = P_BODY;
          end
        end
        P_BODY: begin
          if (riff_left != 0) riff_left = riff_left - 32'd1;
          // pad byte of an odd data chunk is not a sample
          if (tag == TAG_DATA) begin
            if (chunk_left > {32'd0, data_len[0]}) begin
              kind = KIND_SAMPLE;
              smp = b;
            end
          end else if (tag == TAG_FMT) begin
            fmt_byte(b);
          end
          chunk_left = chunk_left - 33'd1;
          if (chunk_left == 33'd0) kind = boundary(kind);
        end
        P_ERROR: kind = KIND_ERR;
        default: phase = P_DONE;
      endcase

      r.byte_kind = kind;
      r.error_code = err;
      r.sample_byte = smp;
      r.audio_format = fmt_format;
      r.channel_count = fmt_channels;
      r.sample_rate = fmt_rate;
      r.bytes_per_sec = fmt_bytes_sec;
      r.bits_per_sample = fmt_bits;
      r.data_size = data_len;
      r.big_endian = big;
      r.header_valid = data_seen;
      expected_parse_q.push_back(r);
      return live;
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
        fail_count++;
      end
    endfunction

    // compare one result item with the oldest expectation
    function void check_result(wrp_res_t got);
      wrp_res_t e;
      if (expected_parse_q.size() == 0) begin
        $display("%0t: result item with nothing expected, actual %p", $time, got);
        fail_count++;
      end else begin
        e = expected_parse_q.pop_front();
        checked_count++;
        cmp("byte_kind", 32'(e.byte_kind), 32'(got.byte_kind));
        cmp("error_code", 32'(e.error_code), 32'(got.error_code));
        cmp("sample_byte", 32'(e.sample_byte), 32'(got.sample_byte));
        cmp("audio_format", 32'(e.audio_format), 32'(got.audio_format));
        cmp("channel_count", 32'(e.channel_count), 32'(got.channel_count));
        cmp("sample_rate", e.sample_rate, got.sample_rate);
        cmp("bytes_per_sec", e.bytes_per_sec, got.bytes_per_sec);
        cmp("bits_per_sample", 32'(e.bits_per_sample), 32'(got.bits_per_sample));
        cmp("data_size", e.data_size, got.data_size);
        cmp("big_endian", 32'(e.big_endian), 32'(got.big_endian));
        cmp("header_valid", 32'(e.header_valid), 32'(got.header_valid));
        if (e.byte_kind == KIND_SAMPLE) sample_count++;
        if (e.byte_kind == KIND_DONE) done_count++;
        if (e.byte_kind == KIND_ERR) error_count++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_file_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_byte_kind;
  logic [1:0]  out_error_code;
  logic [7:0]  out_sample_byte;
  logic [15:0] out_audio_format;
  logic [15:0] out_channel_count;
  logic [31:0] out_sample_rate;
  logic [31:0] out_bytes_per_sec;
  logic [15:0] out_bits_per_sample;
  logic [31:0] out_data_size;
  logic        out_big_endian;
  logic        out_header_valid;

  wav_parse_checker chk = new();
  logic [7:0] body_bytes[$];
  logic [7:0] file_bytes[$];
  int unsigned sent_count = 0;
  int unsigned live_count = 0;
  int unsigned file_count = 0;

  wav_riff_header_parser_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_file_start      (in_file_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_kind      (out_byte_kind),
    .out_error_code     (out_error_code),
    .out_sample_byte    (out_sample_byte),
    .out_audio_format   (out_audio_format),
    .out_channel_count  (out_channel_count),
    .out_sample_rate    (out_sample_rate),
    .out_bytes_per_sec  (out_bytes_per_sec),
    .out_bits_per_sample(out_bits_per_sample),
    .out_data_size      (out_data_size),
    .out_big_endian     (out_big_endian),
    .out_header_valid   (out_header_valid)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // byte i of a 32-bit word in file order
  function automatic logic [7:0] word_byte(logic [31:0] w, int i, logic big_e);
    return big_e ? w[8 * (3 - i) +: 8] : w[8 * i +: 8];
  endfunction

  function automatic logic [31:0] pick_other();
    return ($urandom_range(0, 1) != 0) ? TAG_LIST : $urandom();
  endfunction

  // chunk header plus body_len random body bytes
  function automatic void add_chunk(logic [31:0] tag, logic [31:0] sz, int body_len,
                                    logic big_e);
    int i;
    for (i = 0; i < 4; i++) body_bytes.push_back(word_byte(tag, i, 1'b1));
    for (i = 0; i < 4; i++) body_bytes.push_back(word_byte(sz, i, big_e));
    for (i = 0; i < body_len; i++) body_bytes.push_back(8'($urandom()));
  endfunction

  // random file: mostly well formed, sometimes broken
  task automatic build_file();
    logic        big_e;
    logic        cut;
    logic [31:0] sz, rsize, magic, form;
    int          i, k, start, blen, nfmt, ndata, keep;
    body_bytes.delete();
    file_bytes.delete();
    big_e = 1'($urandom_range(0, 1));
    cut = 1'b0;
    nfmt = ($urandom_range(0, 9) == 0) ? 0 : (($urandom_range(0, 7) == 0) ? 2 : 1);
    ndata = ($urandom_range(0, 9) == 0) ? 0 : (($urandom_range(0, 7) == 0) ? 2 : 1);

    // skipped chunk ahead of fmt
    if ($urandom_range(0, 3) == 0) begin
      sz = $urandom_range(0, 12);
      add_chunk(pick_other(), sz, int'(sz) + int'(sz[0]), big_e);
    end

    // fmt chunks: normal, short or long, with special contents
    for (k = 0; k < nfmt; k++) begin
      case ($urandom_range(0, 7))
        0: sz = $urandom_range(0, 15);
        1: sz = $urandom_range(17, 24);
        default: sz = 32'd16;
      endcase
      start = body_bytes.size() + 8;
      add_chunk(TAG_FMT, sz, int'(sz) + int'(sz[0]), big_e);
      case ($urandom_range(0, 7))
        0: for (i = start; i < body_bytes.size(); i++) body_bytes[i] = 8'hFF;
        1: for (i = start; i < body_bytes.size(); i++) body_bytes[i] = 8'h00;
        2: for (i = start + 4; i < start + 8 && i < body_bytes.size(); i++)
             body_bytes[i] = 8'h00;
        default: ;
      endcase
    end

    // data chunks: empty, small, or huge and cut short
    for (k = 0; k < ndata && !cut; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        sz = $urandom_range(0, 9);
        add_chunk(pick_other(), sz, int'(sz) + int'(sz[0]), big_e);
      end
      case ($urandom_range(0, 11))
        0: add_chunk(TAG_DATA, 32'd0, 0, big_e);
        1: begin
          sz = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom();
          add_chunk(TAG_DATA, sz, $urandom_range(0, 12), big_e);
          cut = 1'b1;
        end
        default: begin
          sz = $urandom_range(1, 16);
          add_chunk(TAG_DATA, sz, int'(sz) + int'(sz[0]), big_e);
        end
      endcase
    end
    if (!cut && $urandom_range(0, 4) == 0) begin
      sz = $urandom_range(0, 12);
      add_chunk(pick_other(), sz, int'(sz) + int'(sz[0]), big_e);
    end

    // riff size: exact, short, tiny or arbitrary
    blen = body_bytes.size();
    case ($urandom_range(0, 19))
      0: rsize = $urandom_range(0, 3);
      1: rsize = $urandom();
      2, 3: rsize = $urandom_range(4, blen + 4);
      default: rsize = blen + 4;
    endcase
    magic = ($urandom_range(0, 19) == 0) ? $urandom() : (big_e ? TAG_RIFX : TAG_RIFF);
    form = ($urandom_range(0, 19) == 0) ? (TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)))
                                        : TAG_WAVE;

    for (i = 0; i < 4; i++) file_bytes.push_back(word_byte(magic, i, 1'b1));
    for (i = 0; i < 4; i++) file_bytes.push_back(word_byte(rsize, i, big_e));
    for (i = 0; i < 4; i++) file_bytes.push_back(word_byte(form, i, 1'b1));
    foreach (body_bytes[i]) file_bytes.push_back(body_bytes[i]);
    if (!cut) repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom()));

    // file broken off before its end
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
  endtask

  // offer one item and wait until it is taken
  task automatic send_byte(logic [7:0] b, logic st);
    bit quiet;
    quiet = (sent_count >= 500) && (sent_count < 700);
    if (!quiet && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_file_start <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (chk.note_byte(b, st)) live_count++;
    sent_count++;
  endtask

  task automatic send_word(logic [31:0] w, logic big_e, logic st);
    int i;
    for (i = 0; i < 4; i++) send_byte(word_byte(w, i, big_e), st && (i == 0));
  endtask

  // result side: check accepted items, random stalls and one long hold-off
  initial begin
    int       hold_left;
    bit       held_once;
    logic     next_stall;
    wrp_res_t got;
    hold_left = 0;
    held_once = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.byte_kind = out_byte_kind;
        got.error_code = out_error_code;
        got.sample_byte = out_sample_byte;
        got.audio_format = out_audio_format;
        got.channel_count = out_channel_count;
        got.sample_rate = out_sample_rate;
        got.bytes_per_sec = out_bytes_per_sec;
        got.bits_per_sample = out_bits_per_sample;
        got.data_size = out_data_size;
        got.big_endian = out_big_endian;
        got.header_valid = out_header_valid;
        chk.check_result(got);
      end
      if (hold_left > 0) begin
        next_stall = 1'b1;
        hold_left--;
      end else if (!held_once && chk.checked_count >= 300) begin
        held_once = 1'b1;
        hold_left = 150;
        next_stall = 1'b1;
      end else if (chk.checked_count >= 500 && chk.checked_count < 700) begin
        next_stall = 1'b0;
      end else begin
        next_stall = ($urandom_range(0, 99) < 25);
      end
      out_stall <= next_stall;
    end
  end

  // reset, stimulus and end of run
  initial begin
    int i, n, w;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bad magic, short riff size in a big-endian file, bad form tag
    send_word(32'hFF00_4946, 1'b1, 1'b1);
    send_word(TAG_RIFX, 1'b1, 1'b1);
    send_word(32'd3, 1'b1, 1'b0);
    send_word(TAG_WAVE, 1'b1, 1'b0);
    send_word(TAG_RIFF, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(TAG_WAVE ^ 32'd1, 1'b1, 1'b0);

    // random files with some noise between them
    while (live_count < LIVE_BYTES) begin
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
          send_byte(8'($urandom()), (i == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
      end else begin
        build_file();
        for (i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == 0);
        file_count++;
      end
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    for (w = 0; w < 5000 && chk.expected_parse_q.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (chk.expected_parse_q.size() != 0) begin
      $display("%0t: %0d expected result items never arrived", $time,
               chk.expected_parse_q.size());
      chk.fail_count++;
    end

    $display("covered %0d bytes in %0d files plus noise: %0d sample bytes,",
             sent_count, file_count, chk.sample_count);
    $display("  %0d clean parse ends, %0d error reports", chk.done_count, chk.error_count);
    if (chk.fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
